/* hdl/mids_pkg.sv */
// Shared types and constants for the Miller index d-spacing block.
package mids_pkg;

  localparam int IndexBits   = 8;
  localparam int CoefBitsDef = 32;
  localparam int RegIdxBits  = 3;
  localparam int RsFrac      = 24;
  localparam int SpFrac      = 16;
  localparam int RootBits    = 32;
  localparam int RadBits     = 64;
  localparam int DivRemBits  = RsFrac + SpFrac + 1;

  localparam logic [RegIdxBits-1:0] RegBxx = 3'd0;
  localparam logic [RegIdxBits-1:0] RegBxy = 3'd1;
  localparam logic [RegIdxBits-1:0] RegBxz = 3'd2;
  localparam logic [RegIdxBits-1:0] RegByy = 3'd3;
  localparam logic [RegIdxBits-1:0] RegByz = 3'd4;
  localparam logic [RegIdxBits-1:0] RegBzz = 3'd5;

  typedef struct packed {
    logic signed [IndexBits-1:0] index_h;
    logic signed [IndexBits-1:0] index_k;
    logic signed [IndexBits-1:0] index_l;
  } req_t;

  typedef struct packed {
    logic [31:0] recip_spacing;
    logic [31:0] spacing;
    logic        zero_vector;
    logic        saturated;
  } rsp_t;

  // Square root chain payload.
  typedef struct packed {
    logic [RadBits-1:0]  rem;
    logic [RootBits-1:0] root;
    logic                sat;
  } sqrt_t;

  // Reciprocal chain payload.
  typedef struct packed {
    logic [RootBits-1:0]   rs;
    logic [DivRemBits-1:0] rem;
    logic [RootBits-1:0]   quot;
    logic                  zero;
    logic                  sat_rs;
    logic                  sat_sp;
  } div_t;

endpackage

/* hdl/mids_sqrt_cell.sv */
// One bit of the integer square root chain.
module mids_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  mids_pkg::sqrt_t d_i,
  output mids_pkg::sqrt_t q_o
);
  import mids_pkg::*;

  logic [RadBits-1:0] trial;
  sqrt_t              nxt;
  sqrt_t              cell_q;

  always_comb begin
    trial = (RadBits'(d_i.root) << (BIT + 1)) | (RadBits'(1) << (2 * BIT));
    nxt   = d_i;
    if (d_i.rem >= trial) begin
      nxt.rem       = d_i.rem - trial;
      nxt.root[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= nxt;
    end
  end

  assign q_o = cell_q;

endmodule

/* hdl/mids_div_cell.sv */
// One quotient bit of the restoring reciprocal chain.
module mids_div_cell #(
  parameter int BIT = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  mids_pkg::div_t d_i,
  output mids_pkg::div_t q_o
);
  import mids_pkg::*;

  logic [RadBits-1:0] dvs;
  div_t               nxt;
  div_t               cell_q;

  always_comb begin
    dvs = RadBits'(d_i.rs) << BIT;
    nxt = d_i;
    if (RadBits'(d_i.rem) >= dvs) begin
      nxt.rem       = DivRemBits'(RadBits'(d_i.rem) - dvs);
      nxt.quot[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= nxt;
    end
  end

  assign q_o = cell_q;

endmodule

/* hdl/miller_index_d_spacing.sv */
// Top level: B times hkl, norm d* by a root chain, and d = 1/d* by a divide chain.
// Pipeline: 4 front stages, 32 square root cells, 32 reciprocal cells,
// and one output register between request accept and result valid.
// Throughput: one request per cycle; the whole pipe advances together and
// holds only while a finished result waits under out_stall_i.
// Reset: rst_ni clears all valid bits and loads B with the identity matrix.
module miller_index_d_spacing #(
  parameter int COEF_BITS = mids_pkg::CoefBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  mids_pkg::req_t                    in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output mids_pkg::rsp_t                    out_rsp_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mids_pkg::RegIdxBits-1:0]   cfg_index_i,
  input  logic [COEF_BITS-1:0]              cfg_data_i
);
  import mids_pkg::*;

  // Fraction bits of B, and width of one vector component before the root.
  localparam int CF   = COEF_BITS - 4;
  localparam int QW   = COEF_BITS + IndexBits + 2;
  localparam int HW   = (QW + 1) / 2;
  localparam int SQW  = 2 * QW;
  localparam int SW   = SQW + 2;
  localparam int SH   = 2 * (CF - RsFrac);
  localparam int POS  = (SH > 0) ? SH : 0;
  localparam int NEG  = (SH < 0) ? -SH : 0;
  localparam int EW   = SW + NEG + RadBits;
  localparam int NST  = 4 + 2 * RootBits;
  localparam logic [COEF_BITS-1:0] One = COEF_BITS'(1) << CF;

  // Configuration registers; writes are always taken.
  logic signed [COEF_BITS-1:0] b_xx_q, b_xy_q, b_xz_q, b_yy_q, b_yz_q, b_zz_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_xx_q <= One;
      b_xy_q <= '0;
      b_xz_q <= '0;
      b_yy_q <= One;
      b_yz_q <= '0;
      b_zz_q <= One;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegBxx:  b_xx_q <= cfg_data_i;
        RegBxy:  b_xy_q <= cfg_data_i;
        RegBxz:  b_xz_q <= cfg_data_i;
        RegByy:  b_yy_q <= cfg_data_i;
        RegByz:  b_yz_q <= cfg_data_i;
        RegBzz:  b_zz_q <= cfg_data_i;
        default: ;  // drop writes past the last register
      endcase
    end
  end

  // Global advance: move everything unless a result is held by the sink.
  logic           en;
  logic [NST-1:0] vld_q;
  logic           out_valid_q;
  rsp_t           out_rsp_q;

  assign en          = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[NST-2:0], in_valid_i};
      out_valid_q <= vld_q[NST-1];
    end
  end

  // Stage 1: signed components of B times hkl.
  logic signed [QW-1:0] h_s, k_s, l_s;
  logic signed [QW-1:0] q_d [3];
  logic signed [QW-1:0] q_q [3];

  always_comb begin
    h_s    = QW'(in_req_i.index_h);
    k_s    = QW'(in_req_i.index_k);
    l_s    = QW'(in_req_i.index_l);
    q_d[0] = QW'(b_xx_q) * h_s + QW'(b_xy_q) * k_s + QW'(b_xz_q) * l_s;
    q_d[1] = QW'(b_yy_q) * k_s + QW'(b_yz_q) * l_s;
    q_d[2] = QW'(b_zz_q) * l_s;
  end

  // Stage 2: magnitudes, split in halves, partial products of each square.
  logic [QW-1:0]   mag [3];
  logic [HW-1:0]   lo [3];
  logic [HW-1:0]   hi [3];
  logic [2*HW-1:0] pll_q [3];
  logic [2*HW-1:0] plh_q [3];
  logic [2*HW-1:0] phh_q [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag[a] = q_q[a][QW-1] ? QW'(-q_q[a]) : QW'(q_q[a]);
      lo[a]  = mag[a][HW-1:0];
      hi[a]  = HW'(mag[a] >> HW);
    end
  end

  // Stage 3: each square; stage 4: sum, align to 48 fraction bits, clip.
  logic [SQW-1:0] sq_q [3];
  logic [SW-1:0]  sum;
  logic [EW-1:0]  aligned;
  sqrt_t          root_in;
  sqrt_t          root_q;

  always_comb begin
    sum             = SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
    aligned         = (EW'(sum) >> POS) << NEG;
    root_in.rem     = aligned[RadBits-1:0];
    root_in.root    = '0;
    root_in.sat     = |aligned[EW-1:RadBits];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_q <= q_d;
      for (int a = 0; a < 3; a++) begin
        pll_q[a] <= (2*HW)'(lo[a]) * (2*HW)'(lo[a]);
        plh_q[a] <= (2*HW)'(lo[a]) * (2*HW)'(hi[a]);
        phh_q[a] <= (2*HW)'(hi[a]) * (2*HW)'(hi[a]);
        sq_q[a]  <= (SQW'(phh_q[a]) << (2 * HW)) + (SQW'(plh_q[a]) << (HW + 1))
                    + SQW'(pll_q[a]);
      end
      root_q <= root_in;
    end
  end

  // Square root chain: one root bit per cell, most significant first.
  sqrt_t sq_link [RootBits+1];
  assign sq_link[0] = root_q;

  for (genvar g = 0; g < RootBits; g++) begin : g_sqrt
    mids_sqrt_cell #(.BIT(RootBits - 1 - g)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (sq_link[g]),
      .q_o   (sq_link[g+1])
    );
  end

  // Reciprocal setup: clip d*, flag zero and too-short norms.
  div_t dv_in;
  always_comb begin
    dv_in.sat_rs = sq_link[RootBits].sat;
    dv_in.rs     = dv_in.sat_rs ? '1 : sq_link[RootBits].root;
    dv_in.rem    = DivRemBits'(1) << (RsFrac + SpFrac);
    dv_in.quot   = '0;
    dv_in.zero   = (dv_in.rs == '0);
    dv_in.sat_sp = !dv_in.zero && (dv_in.rs <= RootBits'(1 << (RsFrac + SpFrac - 32)));
  end

  div_t dv_link [RootBits+1];
  assign dv_link[0] = dv_in;

  for (genvar g = 0; g < RootBits; g++) begin : g_div
    mids_div_cell #(.BIT(RootBits - 1 - g)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (dv_link[g]),
      .q_o   (dv_link[g+1])
    );
  end

  // Output register: override d on zero or clipped reciprocal.
  div_t fin;
  assign fin = dv_link[RootBits];

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_rsp_q.recip_spacing <= fin.rs;
      out_rsp_q.spacing       <= (fin.zero || fin.sat_sp) ? '1 : fin.quot;
      out_rsp_q.zero_vector   <= fin.zero;
      out_rsp_q.saturated     <= fin.sat_rs || fin.sat_sp;
    end
  end

endmodule
